// ===== sv/rk4_second_order_stage_core_assert.svh =====
// assertion macros shared by the rk4 stage core
`ifndef RK4_SECOND_ORDER_STAGE_CORE_ASSERT_SVH
`define RK4_SECOND_ORDER_STAGE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RK4SS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RK4SS_NEVER(lbl, clk, rstn, expr, msg) \
    `RK4SS_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define RK4SS_ASSERT(lbl, clk, rstn, prop, msg)
`define RK4SS_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== sv/rk4ss_pkg.sv =====
package rk4ss_pkg;

    localparam int DATA_W             = 32;
    localparam int STAGE_W            = 3;
    localparam int INDEX_W            = 6;
    localparam int INDEX_SPAN         = 2 ** INDEX_W;
    localparam int STATE_ELEMENTS_DEF = 64;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'h0001_0000;
    localparam logic [23:0]       DIV3_RECIP      = 24'd2731;

    localparam logic [STAGE_W-1:0] STAGE_START = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_HALF  = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_FULL  = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_FINAL = 3'd4;

    localparam logic [1:0] LANE_START = 2'd0;
    localparam logic [1:0] LANE_HALF  = 2'd1;
    localparam logic [1:0] LANE_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_PASS,
        K_START,
        K_HALF,
        K_FULL,
        K_FINAL
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [DATA_W-1:0]           pos;
        logic [DATA_W-1:0]           vel;
        logic [DATA_W-1:0]           acc;
        logic [DATA_W-1:0]           init_p;
        logic [DATA_W-1:0]           init_v;
        logic [2:0][DATA_W-1:0]      hist_v;
        logic [2:0][DATA_W-1:0]      hist_a;
    } t_item;

    typedef struct packed {
        logic [9:0] q;
        logic [1:0] r;
    } t_div3;

    // one radix-1024 digit of an unsigned divide by three
    function automatic t_div3 div3_digit(input logic [1:0] rem, input logic [9:0] dig);
        logic [11:0] v;
        logic [23:0] p;
        logic [11:0] d;
        t_div3       res;
        v     = {rem, dig};
        p     = {12'd0, v} * DIV3_RECIP;
        res.q = p[22:13];
        d     = v - ({2'b00, res.q} + {1'b0, res.q, 1'b0});
        res.r = d[1:0];
        return res;
    endfunction

endpackage

// ===== sv/rk4ss_in_if.sv =====
interface rk4ss_in_if import rk4ss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAGE_W-1:0]        stage;
    logic [INDEX_W-1:0]        element_index;
    logic signed [DATA_W-1:0]  position_in;
    logic signed [DATA_W-1:0]  velocity_in;
    logic signed [DATA_W-1:0]  acceleration_in;

    modport source (output valid, stage, element_index, position_in, velocity_in,
                    acceleration_in, input ready);
    modport sink   (input valid, stage, element_index, position_in, velocity_in,
                    acceleration_in, output ready);
endinterface

// ===== sv/rk4ss_out_if.sv =====
interface rk4ss_out_if import rk4ss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  position_out;
    logic signed [DATA_W-1:0]  velocity_out;
    logic                      full_step;
    logic                      saturated;

    modport source (output valid, position_out, velocity_out, full_step, saturated,
                    input ready);
    modport sink   (input valid, position_out, velocity_out, full_step, saturated,
                    output ready);
endinterface

// ===== sv/rk4ss_front.sv =====
module rk4ss_front import rk4ss_pkg::*; #(
    parameter int STATE_ELEMENTS = STATE_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rk4ss_in_if.sink    i_in,
    output logic        o_item_valid,
    input  logic        i_item_ready,
    output t_item       o_item
);

    localparam int AW = (STATE_ELEMENTS > 1) ? $clog2(STATE_ELEMENTS) : 1;

    logic [DATA_W-1:0]      r_mem_init_p [STATE_ELEMENTS];
    logic [DATA_W-1:0]      r_mem_init_v [STATE_ELEMENTS];
    logic [2:0][DATA_W-1:0] r_mem_hist_v [STATE_ELEMENTS];
    logic [2:0][DATA_W-1:0] r_mem_hist_a [STATE_ELEMENTS];

    logic                   r_valid;
    t_item                  r_item;
    logic [AW-1:0]          w_wrap [INDEX_SPAN];
    logic [AW-1:0]          w_addr;
    t_kind                  w_kind;
    logic [1:0]             w_lane;
    logic                   w_hist_we;
    logic                   w_accept;

    // index wrap table, folded at elaboration
    for (genvar gi = 0; gi < INDEX_SPAN; gi++) begin : g_wrap
        assign w_wrap[gi] = AW'(gi % STATE_ELEMENTS);
    end

    assign w_addr   = w_wrap[i_in.element_index];
    assign i_in.ready = !r_valid || i_item_ready;
    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        w_kind    = K_PASS;
        w_lane    = LANE_START;
        w_hist_we = 1'b0;
        case (i_in.stage)
            STAGE_START: begin
                w_kind    = K_START;
                w_lane    = LANE_START;
                w_hist_we = 1'b1;
            end
            STAGE_HALF: begin
                w_kind    = K_HALF;
                w_lane    = LANE_HALF;
                w_hist_we = 1'b1;
            end
            STAGE_FULL: begin
                w_kind    = K_FULL;
                w_lane    = LANE_FULL;
                w_hist_we = 1'b1;
            end
            STAGE_FINAL: begin
                w_kind    = K_FINAL;
            end
            default: begin
                w_kind    = K_PASS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    // stores and registered read, same edge as the transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.kind   <= w_kind;
            r_item.pos    <= i_in.position_in;
            r_item.vel    <= i_in.velocity_in;
            r_item.acc    <= i_in.acceleration_in;
            r_item.init_p <= r_mem_init_p[w_addr];
            r_item.init_v <= r_mem_init_v[w_addr];
            r_item.hist_v <= r_mem_hist_v[w_addr];
            r_item.hist_a <= r_mem_hist_a[w_addr];
            if (w_kind == K_START) begin
                r_mem_init_p[w_addr] <= i_in.position_in;
                r_mem_init_v[w_addr] <= i_in.velocity_in;
            end
            if (w_hist_we) begin
                r_mem_hist_v[w_addr][w_lane] <= i_in.velocity_in;
                r_mem_hist_a[w_addr][w_lane] <= i_in.acceleration_in;
            end
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== sv/rk4ss_queue.sv =====
`include "rk4_second_order_stage_core_assert.svh"

module rk4ss_queue import rk4ss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_buf [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_buf[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_push_item;
        end
    end

    `RK4SS_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(QUEUE_DEPTH), "queue overfilled")
    `RK4SS_ASSERT(a_push_grows, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1), "count lost a push")
    `RK4SS_ASSERT(a_pop_shrinks, i_clk, i_rst_n, (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1), "count lost a pop")

endmodule

// ===== sv/rk4ss_back.sv =====
`include "rk4_second_order_stage_core_assert.svh"

module rk4ss_back import rk4ss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DATA_W-1:0]  i_time_step,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    input  t_item              i_item,
    rk4ss_out_if.source        o_out
);

    localparam int S_W = 35;
    localparam int P_W = 52;
    localparam int N_W = 68;
    localparam int M_W = 36;
    localparam int B_W = 40;
    localparam int E_W = 37;

    localparam logic signed [N_W-1:0] RND_FULL  = 68'sd32768;
    localparam logic signed [N_W-1:0] RND_HALF  = 68'sd65536;
    localparam logic signed [N_W-1:0] RND_SIXTH = 68'sd196608;
    localparam logic signed [N_W-1:0] M_MAX     = 68'sd34359738367;
    localparam logic signed [N_W-1:0] M_MIN     = -68'sd34359738368;
    localparam logic [B_W-1:0]        B_BIAS    = 40'd103079215104;
    localparam logic [B_W-1:0]        B_OFF     = 40'd34359738368;
    localparam logic signed [E_W-1:0] OUT_MAX   = 37'sd2147483647;
    localparam logic signed [E_W-1:0] OUT_MIN   = -37'sd2147483648;
    localparam logic signed [DATA_W-1:0] RAIL_HI = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] RAIL_LO = 32'sh8000_0000;

    logic                       w_en;
    logic [6:0]                 r_vld;
    t_kind                      r_kind [6];
    logic signed [DATA_W-1:0]   r_base [6][2];
    logic signed [S_W-1:0]      r_s    [2];
    logic signed [P_W-1:0]      r_pa   [2];
    logic signed [P_W-1:0]      r_pb   [2];
    logic signed [N_W-1:0]      r_n    [2];
    logic signed [M_W-1:0]      r_m    [2];
    logic signed [M_W-1:0]      r_m4   [2];
    logic [19:0]                r_qhi  [2];
    logic [1:0]                 r_rem  [2];
    logic [19:0]                r_blo  [2];
    logic signed [M_W-1:0]      r_inc  [2];
    logic signed [DATA_W-1:0]   r_out_p;
    logic signed [DATA_W-1:0]   r_out_v;
    logic                       r_out_full;
    logic                       r_out_sat;

    logic signed [DATA_W-1:0]   n_base [2];
    logic signed [S_W-1:0]      n_s    [2];
    logic signed [N_W-1:0]      n_n    [2];
    logic signed [N_W-1:0]      w_shr  [2];
    logic signed [M_W-1:0]      n_m    [2];
    logic [B_W-1:0]             w_b    [2];
    t_div3                      w_d3   [2];
    t_div3                      w_d2   [2];
    t_div3                      w_d1   [2];
    t_div3                      w_d0   [2];
    logic [B_W-1:0]             w_q    [2];
    logic signed [M_W-1:0]      n_inc  [2];
    logic signed [E_W-1:0]      w_sum  [2];
    logic signed [DATA_W-1:0]   n_out  [2];
    logic [1:0]                 w_clip;
    logic signed [DATA_W-1:0]   w_drv  [2];
    logic [2:0][DATA_W-1:0]     w_hist [2];

    // whole pipe advances together, output register is the last stage
    assign w_en         = !r_vld[6] || o_out.ready;
    assign o_item_ready = w_en;

    always_comb begin
        w_drv[0]  = $signed(i_item.vel);
        w_drv[1]  = $signed(i_item.acc);
        w_hist[0] = i_item.hist_v;
        w_hist[1] = i_item.hist_a;
        if (i_item.kind == K_START || i_item.kind == K_PASS) begin
            n_base[0] = $signed(i_item.pos);
            n_base[1] = $signed(i_item.vel);
        end else begin
            n_base[0] = $signed(i_item.init_p);
            n_base[1] = $signed(i_item.init_v);
        end
        for (int i = 0; i < 2; i++) begin
            case (i_item.kind)
                K_PASS:  n_s[i] = '0;
                K_FINAL: n_s[i] = S_W'($signed(w_hist[i][0]))
                                + (S_W'($signed(w_hist[i][1])) <<< 1)
                                + (S_W'($signed(w_hist[i][2])) <<< 1)
                                + S_W'(w_drv[i]);
                default: n_s[i] = S_W'(w_drv[i]);
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            // rounding bias is half of the final divisor
            case (r_kind[1])
                K_FULL:  n_n[i] = (N_W'(r_pa[i]) <<< 16) + N_W'(r_pb[i]) + RND_FULL;
                K_FINAL: n_n[i] = (N_W'(r_pa[i]) <<< 16) + N_W'(r_pb[i]) + RND_SIXTH;
                default: n_n[i] = (N_W'(r_pa[i]) <<< 16) + N_W'(r_pb[i]) + RND_HALF;
            endcase
            w_shr[i] = (r_kind[2] == K_FULL) ? (r_n[i] >>> 16) : (r_n[i] >>> 17);
            // clamp keeps the sign, anything past it saturates regardless
            if (w_shr[i] > M_MAX) begin
                n_m[i] = M_W'(M_MAX);
            end else if (w_shr[i] < M_MIN) begin
                n_m[i] = M_W'(M_MIN);
            end else begin
                n_m[i] = M_W'(w_shr[i]);
            end
            // floor divide by three on a biased non-negative value
            w_b[i]  = B_W'(r_m[i]) + B_BIAS;
            w_d3[i] = div3_digit(2'd0, w_b[i][39:30]);
            w_d2[i] = div3_digit(w_d3[i].r, w_b[i][29:20]);
            w_d1[i] = div3_digit(r_rem[i], r_blo[i][19:10]);
            w_d0[i] = div3_digit(w_d1[i].r, r_blo[i][9:0]);
            w_q[i]  = {r_qhi[i], w_d1[i].q, w_d0[i].q};
            if (r_kind[4] == K_FINAL) begin
                n_inc[i] = M_W'(w_q[i] - B_OFF);
            end else begin
                n_inc[i] = r_m4[i];
            end
            w_sum[i] = E_W'(r_base[5][i]) + E_W'(r_inc[i]);
            if (w_sum[i] > OUT_MAX) begin
                n_out[i]  = RAIL_HI;
                w_clip[i] = 1'b1;
            end else if (w_sum[i] < OUT_MIN) begin
                n_out[i]  = RAIL_LO;
                w_clip[i] = 1'b1;
            end else begin
                n_out[i]  = DATA_W'(w_sum[i]);
                w_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:0], i_item_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind[0] <= i_item.kind;
            r_base[0] <= n_base;
            for (int k = 1; k < 6; k++) begin
                r_kind[k] <= r_kind[k-1];
                r_base[k] <= r_base[k-1];
            end
            for (int i = 0; i < 2; i++) begin
                r_s[i]   <= n_s[i];
                r_pa[i]  <= r_s[i] * $signed({1'b0, i_time_step[31:16]});
                r_pb[i]  <= r_s[i] * $signed({1'b0, i_time_step[15:0]});
                r_n[i]   <= n_n[i];
                r_m[i]   <= n_m[i];
                r_m4[i]  <= r_m[i];
                r_qhi[i] <= {w_d3[i].q, w_d2[i].q};
                r_rem[i] <= w_d2[i].r;
                r_blo[i] <= w_b[i][19:0];
                r_inc[i] <= n_inc[i];
            end
            r_out_p    <= n_out[0];
            r_out_v    <= n_out[1];
            r_out_full <= (r_kind[5] != K_START) && (r_kind[5] != K_HALF);
            r_out_sat  <= |w_clip;
        end
    end

    assign o_out.valid        = r_vld[6];
    assign o_out.position_out = r_out_p;
    assign o_out.velocity_out = r_out_v;
    assign o_out.full_step    = r_out_full;
    assign o_out.saturated    = r_out_sat;

    `RK4SS_ASSERT(a_sat_on_rail, i_clk, i_rst_n, (r_vld[6] && r_out_sat) |-> (r_out_p == RAIL_HI || r_out_p == RAIL_LO || r_out_v == RAIL_HI || r_out_v == RAIL_LO), "saturation flagged off the rails")
    `RK4SS_ASSERT(a_pass_no_inc, i_clk, i_rst_n, (r_vld[5] && r_kind[5] == K_PASS) |-> (r_inc[0] == '0 && r_inc[1] == '0), "pass-through item moved")
    `RK4SS_ASSERT(a_pipe_advance, i_clk, i_rst_n, (w_en && r_vld[5]) |=> r_vld[6], "item dropped before output")

endmodule

// ===== sv/rk4_second_order_stage_core.sv =====
// rk4 second-order stage core
// one classic rk4 stage for x'' = a, one state element per transfer, q16.16
// channels: i_in carries stage, element index, position, velocity and
// acceleration; o_out returns propagated position and velocity, a full-step
// flag and a saturation flag, exactly one result per input transfer
// config: i_cfg_we / i_cfg_data write the time step (unsigned q16.16); the
// user must do so only while the core is idle, which the core does not
// enforce; reset value is 1.0
// path: the front register loads on the input transfer edge, then 1 queue
// slot and 7 back stages (operand select, multiply, round, shift and clamp,
// divide by three over two stages, saturate into the output register)
// throughput: one item per cycle while o_out.ready is high, set by element
// stores accessed on the transfer edge and the fully pipelined back end
// reset: synchronous active low, clears control state and sets the time
// step to 1.0; element stores are not cleared, stage 1 of an element must
// precede the other stages of that element
// receiver stall: the output register holds, the back end freezes, the
// 4-entry queue absorbs items, then i_in.ready drops
module rk4_second_order_stage_core import rk4ss_pkg::*; #(
    parameter int STATE_ELEMENTS = STATE_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DATA_W-1:0]  i_cfg_data,
    rk4ss_in_if.sink           i_in,
    rk4ss_out_if.source        o_out
);

    logic [DATA_W-1:0] r_time_step;
    logic              w_f_valid;
    logic              w_f_ready;
    t_item             w_f_item;
    logic              w_q_valid;
    logic              w_q_ready;
    t_item             w_q_item;

    // time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_data;
        end
    end

    // front: accept, classify, element store access
    rk4ss_front #(
        .STATE_ELEMENTS (STATE_ELEMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_f_ready),
        .o_item       (w_f_item)
    );

    // decoupling queue between front and back
    rk4ss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_item  (w_f_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    // back: arithmetic pipeline and output register
    rk4ss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_time_step  (r_time_step),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out        (o_out)
    );

endmodule
